// ----- rtl/assert_macros.svh -----
// assertion macros shared by the expander rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define PSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/pse_pkg.sv -----
// package for the png sample to rgba8 expander
// types, codes, constants and the grey scale table; no dependencies
package pse_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned CT_W     = 3;
  localparam int unsigned BD_W     = 5;
  localparam int unsigned CNT_W    = 3;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [CT_W-1:0]   COLOR_TYPE_RST = 3'd0;
  localparam logic [BD_W-1:0]   BIT_DEPTH_RST  = 5'd8;
  localparam logic [BD_W-1:0]   DEPTH_8        = 5'd8;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE   = 8'd255;
  localparam logic [CNT_W-1:0]  CNT_RGB        = 3'd3;
  localparam logic [CNT_W-1:0]  CNT_RGBA       = 3'd4;

  typedef enum logic [CT_W-1:0] {
    CT_GREY       = 3'd0,
    CT_RGB        = 3'd2,
    CT_INDEXED    = 3'd3,
    CT_GREY_ALPHA = 3'd4,
    CT_RGBA       = 3'd6
  } color_type_e;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_COLOR_TYPE = 1'b0,
    REG_BIT_DEPTH  = 1'b1
  } reg_idx_e;

  // control carried alongside the lane samples
  typedef struct packed {
    logic [CT_W-1:0]   color_type;
    logic              scale_en;
    logic [CHAN_W-1:0] scale;
    logic              pal_hit;
  } s1_ctrl_t;

  // grey multiplier for depths below 8: floor(255 / (2^d - 1)), 1 at depth 0
  function automatic logic [CHAN_W-1:0] grey_scale(input logic [2:0] depth);
    logic [CHAN_W-1:0] s;
    case (depth)
      3'd0:    s = 8'd1;
      3'd1:    s = 8'd255;
      3'd2:    s = 8'd85;
      3'd3:    s = 8'd36;
      3'd4:    s = 8'd17;
      3'd5:    s = 8'd8;
      3'd6:    s = 8'd4;
      default: s = 8'd2;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/png_sample_to_rgba8_expander_top.sv -----
// Converts one unpacked PNG pixel per beat into 8-bit RGBA and takes palette
// write beats (tuser low) into a 256-entry palette; write color_type and
// bit_depth over APB only while the block is empty. Throughput is one beat
// per clock unless the output stalls; a pixel result is held first in the
// lane/palette read register and then in the output register. Palette
// writes and pixels of an unknown color type produce no output beat.
// Depends on pse_pkg, pse_lane, pse_palette, pse_merge and assert_macros.svh.
module png_sample_to_rgba8_expander_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pse_pkg::APB_AW-1:0]        paddr,
  input  logic [pse_pkg::APB_DW-1:0]        pwdata,
  output logic [pse_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // palette_index, palette_rgb, sample_a, sample_b, sample_c, sample_d
  input  logic [pse_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // opcode
  input  logic                              s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red, green, blue, alpha, channel_count, zero pad
  output logic [pse_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import pse_pkg::*;

  `include "assert_macros.svh"

  logic [CT_W-1:0]   color_type_q;
  logic [BD_W-1:0]   bit_depth_q;
  logic              cfg_wr;

  logic [CHAN_W-1:0] pal_index;
  logic [RGB_W-1:0]  pal_rgb;
  logic              s_accept, is_pixel, ct_known, pal_wr_ok;
  logic              take;

  logic              s1_valid_q, s1_valid_d;
  s1_ctrl_t          s1_ctrl_q, s1_ctrl_d;

  logic [CHAN_W-1:0] prep_a, prep_b, prep_c, prep_d;
  logic [CHAN_W-1:0] lane_a, lane_b, lane_c, lane_d;
  logic [RGB_W-1:0]  pal_rdata;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_type_q <= COLOR_TYPE_RST;
      bit_depth_q  <= BIT_DEPTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_COLOR_TYPE: color_type_q <= pwdata[CT_W-1:0];
        REG_BIT_DEPTH:  bit_depth_q  <= pwdata[BD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_COLOR_TYPE: prdata = APB_DW'(color_type_q);
      REG_BIT_DEPTH:  prdata = APB_DW'(bit_depth_q);
      default:        prdata = '0;
    endcase
  end

  // input beat decode
  assign pal_index = s_axis_tdata[7:0];
  assign pal_rgb   = s_axis_tdata[31:8];
  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign is_pixel  = opcode_e'(s_axis_tuser) == OP_PIXEL;
  assign pal_wr_ok = {1'b0, pal_index} < 9'(PALETTE_ENTRIES);

  always_comb begin
    case (color_type_q) inside
      CT_GREY, CT_RGB, CT_INDEXED, CT_GREY_ALPHA, CT_RGBA: ct_known = 1'b1;
      default:                                             ct_known = 1'b0;
    endcase
  end

  assign s_axis_tready = !s1_valid_q || take;

  // sample lanes
  pse_lane u_lane_a (
    .clk_i, .en_i(s_accept), .sample_i(s_axis_tdata[47:32]),
    .bit_depth_i(bit_depth_q), .prep_o(prep_a), .prep_q_o(lane_a)
  );
  pse_lane u_lane_b (
    .clk_i, .en_i(s_accept), .sample_i(s_axis_tdata[63:48]),
    .bit_depth_i(bit_depth_q), .prep_o(prep_b), .prep_q_o(lane_b)
  );
  pse_lane u_lane_c (
    .clk_i, .en_i(s_accept), .sample_i(s_axis_tdata[79:64]),
    .bit_depth_i(bit_depth_q), .prep_o(prep_c), .prep_q_o(lane_c)
  );
  pse_lane u_lane_d (
    .clk_i, .en_i(s_accept), .sample_i(s_axis_tdata[95:80]),
    .bit_depth_i(bit_depth_q), .prep_o(prep_d), .prep_q_o(lane_d)
  );

  pse_palette u_palette (
    .clk_i,
    .we_i   (s_accept && !is_pixel && pal_wr_ok),
    .waddr_i(pal_index[PAL_AW-1:0]),
    .wdata_i(pal_rgb),
    .re_i   (s_accept),
    .raddr_i(prep_a[PAL_AW-1:0]),
    .rdata_o(pal_rdata)
  );

  // stage one control
  always_comb begin
    s1_ctrl_d.color_type = color_type_q;
    s1_ctrl_d.scale_en   = bit_depth_q < DEPTH_8;
    s1_ctrl_d.scale      = grey_scale(bit_depth_q[2:0]);
    s1_ctrl_d.pal_hit    = {1'b0, prep_a} < 9'(PALETTE_ENTRIES);
  end

  assign s1_valid_d = s_accept ? (is_pixel && ct_known) : (s1_valid_q && !take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_ctrl_q <= s1_ctrl_d;
    end
  end

  pse_merge u_merge (
    .clk_i,
    .rst_ni,
    .s1_valid_i(s1_valid_q),
    .s1_ctrl_i (s1_ctrl_q),
    .lane_a_i  (lane_a),
    .lane_b_i  (lane_b),
    .lane_c_i  (lane_c),
    .lane_d_i  (lane_d),
    .pal_rgb_i (pal_rdata),
    .take_o    (take),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  `PSE_ASSERT_NEXT(a_pal_write_no_result, s_accept && !is_pixel, !s1_valid_q)
  `PSE_ASSERT_NOW(a_full_stall_blocks_input,
                  s1_valid_q && m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `PSE_ASSERT_NOW(a_rgb_alpha_zero,
                  m_axis_tvalid && m_axis_tdata[34:32] == CNT_RGB, m_axis_tdata[31:24] == '0)

endmodule

// ----- rtl/pse_lane.sv -----
// one sample lane: depth reduction or masking of a 16-bit sample to 8 bits
// depends on pse_pkg
module pse_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [pse_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [pse_pkg::BD_W-1:0]      bit_depth_i,
  output logic [pse_pkg::CHAN_W-1:0]    prep_o,
  output logic [pse_pkg::CHAN_W-1:0]    prep_q_o
);
  import pse_pkg::*;

  logic [CHAN_W-1:0] hi, lo, mask;
  logic [CHAN_W-1:0] prep_q;

  assign hi   = sample_i[SAMPLE_W-1:CHAN_W];
  assign lo   = sample_i[CHAN_W-1:0];
  assign mask = CHAN_W'((16'd1 << bit_depth_i[2:0]) - 16'd1);

  // floor(s / 257) is hi or hi - 1
  always_comb begin
    if (bit_depth_i > DEPTH_8) begin
      prep_o = hi - CHAN_W'(hi > lo);
    end else if (bit_depth_i == DEPTH_8 || bit_depth_i == '0) begin
      prep_o = lo;
    end else begin
      prep_o = lo & mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_o;
    end
  end

  assign prep_q_o = prep_q;

endmodule

// ----- rtl/pse_palette.sv -----
// palette store, one write port and one registered read port
// depends on pse_pkg
module pse_palette (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [pse_pkg::PAL_AW-1:0]  waddr_i,
  input  logic [pse_pkg::RGB_W-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [pse_pkg::PAL_AW-1:0]  raddr_i,
  output logic [pse_pkg::RGB_W-1:0]   rdata_o
);
  import pse_pkg::*;

  logic [RGB_W-1:0] mem [PALETTE_ENTRIES];
  logic [RGB_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pse_merge.sv -----
// merge stage: combines lane samples and palette data into one rgba beat
// depends on pse_pkg
module pse_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s1_valid_i,
  input  pse_pkg::s1_ctrl_t                 s1_ctrl_i,
  input  logic [pse_pkg::CHAN_W-1:0]        lane_a_i,
  input  logic [pse_pkg::CHAN_W-1:0]        lane_b_i,
  input  logic [pse_pkg::CHAN_W-1:0]        lane_c_i,
  input  logic [pse_pkg::CHAN_W-1:0]        lane_d_i,
  input  logic [pse_pkg::RGB_W-1:0]         pal_rgb_i,
  output logic                              take_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red, green, blue, alpha, channel_count, zero pad
  output logic [pse_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import pse_pkg::*;

  logic                  valid_q, valid_d;
  logic [CHAN_W-1:0]     red_d, green_d, blue_d, alpha_d;
  logic [CNT_W-1:0]      cnt_d;
  logic [CHAN_W-1:0]     grey;
  logic [2*CHAN_W-1:0]   grey_prod;
  logic [RGB_W-1:0]      pal;
  logic [OUT_DATA_W-1:0] data_q;

  assign grey_prod = lane_a_i * s1_ctrl_i.scale;
  assign grey      = s1_ctrl_i.scale_en ? grey_prod[CHAN_W-1:0] : lane_a_i;
  assign pal       = s1_ctrl_i.pal_hit ? pal_rgb_i : '0;

  always_comb begin
    red_d   = lane_a_i;
    green_d = lane_b_i;
    blue_d  = lane_c_i;
    alpha_d = lane_d_i;
    cnt_d   = CNT_RGBA;
    case (s1_ctrl_i.color_type)
      CT_GREY: begin
        red_d   = grey;
        green_d = grey;
        blue_d  = grey;
        alpha_d = ALPHA_OPAQUE;
      end
      CT_RGB: begin
        alpha_d = '0;
        cnt_d   = CNT_RGB;
      end
      CT_INDEXED: begin
        red_d   = pal[23:16];
        green_d = pal[15:8];
        blue_d  = pal[7:0];
        alpha_d = ALPHA_OPAQUE;
      end
      CT_GREY_ALPHA: begin
        green_d = lane_a_i;
        blue_d  = lane_a_i;
        alpha_d = lane_b_i;
      end
      default: begin
      end
    endcase
  end

  assign take_o  = !valid_q || m_axis_tready;
  assign valid_d = take_o ? s1_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && s1_valid_i) begin
      data_q <= {5'b0, cnt_d, alpha_d, blue_d, green_d, red_d};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule
